/* hw/rtl/sbst_pkg.sv */
`default_nettype none
package sbst_pkg;

   // default sizes
   localparam int GRID_MAX_DEF   = 16;
   localparam int VECTOR_MAX_DEF = 16;

   // operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_TRAIN = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // register indexes
   localparam logic [2:0] REG_GRID_WIDTH     = 3'd0;
   localparam logic [2:0] REG_GRID_HEIGHT    = 3'd1;
   localparam logic [2:0] REG_VECTOR_LENGTH  = 3'd2;
   localparam logic [2:0] REG_INITIAL_RATE   = 3'd3;
   localparam logic [2:0] REG_INITIAL_RADIUS = 3'd4;

   // reset values
   localparam logic [4:0]  SIZE_RESET   = 5'd16;
   localparam logic [15:0] RATE_RESET   = 16'd32768;
   localparam logic [12:0] RADIUS_RESET = 13'd2048;
   localparam logic [12:0] RADIUS_MIN   = 13'd256;

   // arithmetic constants
   localparam logic [15:0] DECAY_Q16   = 16'd65470;
   localparam logic [19:0] LOG2E_X8    = 20'd756384;
   localparam int          EXP_SAT     = 272;
   localparam logic [32:0] HALF_Q16    = 33'd32768;

   typedef logic [16:0] exp_tab_type [16];
   localparam exp_tab_type EXP2_FRAC = '{
      17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773, 17'd50535, 17'd48393,
      17'd46341, 17'd44376, 17'd42495, 17'd40693, 17'd38968, 17'd37316, 17'd35734, 17'd34219
   };

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  node_x;
      logic [3:0]  node_y;
      logic [3:0]  element_index;
      logic [15:0] value;
      logic        last;
   } req_beat_type;

   typedef struct packed {
      logic accept;
      logic rd;
      logic sq_en;
      logic acc_en;
      logic cmp_en;
      logic d2_en;
      logic div_start;
      logic div_step;
      logic infl_en;
      logic gain_en;
      logic mul_en;
      logic wr_en;
      logic decay_en;
      logic rsp_load;
      logic train;
   } cmd_type;

   // size register clamped to 1..hi
   function automatic int clamp_size(logic [4:0] v, int hi);
      int r;
      r = int'(v);
      if (r < 1) r = 1;
      if (r > hi) r = hi;
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/sbst_req_if.sv */
`default_nettype none
interface sbst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [3:0]  node_x;
   logic [3:0]  node_y;
   logic [3:0]  element_index;
   logic signed [15:0] value;
   logic        last;
   modport source (output valid, operation, node_x, node_y, element_index, value, last,
                   input ready);
   modport sink (input valid, operation, node_x, node_y, element_index, value, last,
                 output ready);
endinterface
`default_nettype wire

/* hw/rtl/sbst_rsp_if.sv */
`default_nettype none
interface sbst_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] bmu_x;
   logic [3:0] bmu_y;
   logic       weights_updated;
   modport source (output valid, bmu_x, bmu_y, weights_updated, input ready);
   modport sink (input valid, bmu_x, bmu_y, weights_updated, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sbst_csr_if.sv */
`default_nettype none
interface sbst_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sbst_ctrl.sv */
`default_nettype none
module sbst_ctrl #(
   parameter int GRID_MAX   = sbst_pkg::GRID_MAX_DEF,
   parameter int VECTOR_MAX = sbst_pkg::VECTOR_MAX_DEF,
   localparam int GX_W      = $clog2(GRID_MAX),
   localparam int VD_W      = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_op,
   input  wire logic                 req_last,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [GX_W-1:0]      gw_last,
   input  wire logic [GX_W-1:0]      gh_last,
   input  wire logic [VD_W-1:0]      vl_last,
   output sbst_pkg::cmd_type         cmd,
   output logic [GX_W-1:0]           x_idx,
   output logic [GX_W-1:0]           y_idx,
   output logic [VD_W-1:0]           d_idx
);
   localparam int NUM_W = 2 * GX_W + 21;
   localparam int CNT_W = $clog2(NUM_W);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_S_RD   = 4'd1;
   localparam logic [3:0] ST_S_MUL  = 4'd2;
   localparam logic [3:0] ST_S_ACC  = 4'd3;
   localparam logic [3:0] ST_S_CMP  = 4'd4;
   localparam logic [3:0] ST_T_D2   = 4'd5;
   localparam logic [3:0] ST_T_NUM  = 4'd6;
   localparam logic [3:0] ST_T_DIV  = 4'd7;
   localparam logic [3:0] ST_T_INFL = 4'd8;
   localparam logic [3:0] ST_T_GAIN = 4'd9;
   localparam logic [3:0] ST_U_RD   = 4'd10;
   localparam logic [3:0] ST_U_MUL  = 4'd11;
   localparam logic [3:0] ST_U_WR   = 4'd12;
   localparam logic [3:0] ST_DECAY  = 4'd13;
   localparam logic [3:0] ST_DONE   = 4'd14;

   logic [3:0]       state_ff, state_in;
   logic [GX_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [VD_W-1:0]  d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             train_ff, train_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             d_end, node_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign x_idx     = x_ff;
   assign y_idx     = y_ff;
   assign d_idx     = d_ff;
   assign d_end     = (d_ff == vl_last);
   assign node_end  = (x_ff == gw_last) && (y_ff == gh_last);

   // sequencer
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      cnt_in   = cnt_ff;
      train_in = train_ff;
      cmd      = '0;
      cmd.accept = accept;
      cmd.train  = train_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last &&
                (req_op == sbst_pkg::OP_TRAIN || req_op == sbst_pkg::OP_QUERY)) begin
               train_in = (req_op == sbst_pkg::OP_TRAIN);
               x_in     = '0;
               y_in     = '0;
               d_in     = '0;
               state_in = ST_S_RD;
            end
         end
         ST_S_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_S_MUL;
         end
         ST_S_MUL: begin
            cmd.sq_en = 1'b1;
            state_in  = ST_S_ACC;
         end
         ST_S_ACC: begin
            cmd.acc_en = 1'b1;
            if (d_end) begin
               d_in     = '0;
               state_in = ST_S_CMP;
            end else begin
               d_in     = d_ff + 1'b1;
               state_in = ST_S_RD;
            end
         end
         ST_S_CMP: begin
            cmd.cmp_en = 1'b1;
            if (x_ff == gw_last) begin
               x_in = '0;
               if (y_ff == gh_last) begin
                  y_in     = '0;
                  state_in = train_ff ? ST_T_D2 : ST_DONE;
               end else begin
                  y_in     = y_ff + 1'b1;
                  state_in = ST_S_RD;
               end
            end else begin
               x_in     = x_ff + 1'b1;
               state_in = ST_S_RD;
            end
         end
         ST_T_D2: begin
            cmd.d2_en = 1'b1;
            state_in  = ST_T_NUM;
         end
         ST_T_NUM: begin
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = ST_T_DIV;
         end
         ST_T_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) state_in = ST_T_INFL;
         end
         ST_T_INFL: begin
            cmd.infl_en = 1'b1;
            state_in    = ST_T_GAIN;
         end
         ST_T_GAIN: begin
            cmd.gain_en = 1'b1;
            d_in        = '0;
            state_in    = ST_U_RD;
         end
         ST_U_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_U_MUL;
         end
         ST_U_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_U_WR;
         end
         ST_U_WR: begin
            cmd.wr_en = 1'b1;
            if (d_end) begin
               d_in = '0;
               if (node_end) begin
                  state_in = ST_DECAY;
               end else begin
                  if (x_ff == gw_last) begin
                     x_in = '0;
                     y_in = y_ff + 1'b1;
                  end else begin
                     x_in = x_ff + 1'b1;
                  end
                  state_in = ST_T_D2;
               end
            end else begin
               d_in     = d_ff + 1'b1;
               state_in = ST_U_RD;
            end
         end
         ST_DECAY: begin
            cmd.decay_en = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result beat held until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         d_ff         <= '0;
         cnt_ff       <= '0;
         train_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         d_ff         <= d_in;
         cnt_ff       <= cnt_in;
         train_ff     <= train_in;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/sbst_dpath.sv */
`default_nettype none
module sbst_dpath #(
   parameter int GRID_MAX   = sbst_pkg::GRID_MAX_DEF,
   parameter int VECTOR_MAX = sbst_pkg::VECTOR_MAX_DEF,
   localparam int GX_W      = $clog2(GRID_MAX),
   localparam int VD_W      = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sbst_pkg::req_beat_type req_beat,
   input  wire logic                  csr_accept,
   input  wire logic [2:0]            csr_index,
   input  wire logic [15:0]           csr_data,
   input  wire sbst_pkg::cmd_type     cmd,
   input  wire logic [GX_W-1:0]       x_idx,
   input  wire logic [GX_W-1:0]       y_idx,
   input  wire logic [VD_W-1:0]       d_idx,
   output logic [GX_W-1:0]            gw_last,
   output logic [GX_W-1:0]            gh_last,
   output logic [VD_W-1:0]            vl_last,
   output logic [3:0]                 rsp_bmu_x,
   output logic [3:0]                 rsp_bmu_y,
   output logic                       rsp_updated
);
   localparam int DEPTH  = GRID_MAX * GRID_MAX * VECTOR_MAX;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int D2_W   = 2 * GX_W + 1;
   localparam int NUM_W  = D2_W + 20;
   localparam int DIST_W = 34 + VD_W;

   // configuration and working registers
   logic [4:0]  grid_width_ff, grid_height_ff, vector_length_ff;
   logic [15:0] rate_ff;
   logic [12:0] radius_ff;

   // memories
   logic [15:0] weight_mem [DEPTH];
   logic [15:0] input_mem [VECTOR_MAX];
   logic [15:0] w_rd_ff, in_rd_ff;

   logic [ADDR_W-1:0] cur_addr, req_addr, w_waddr;
   logic [15:0]       w_wdata, new_w;
   logic              w_we, in_we, req_in_range;

   // search path
   logic signed [16:0] diff_s;
   logic signed [33:0] sq_full;
   logic [32:0]        sq_ff;
   logic [DIST_W-1:0]  acc_ff, best_ff;
   logic [GX_W-1:0]    bx_ff, by_ff;

   // influence path
   logic signed [GX_W:0]     dx, dy;
   logic signed [2*GX_W+1:0] dx2, dy2;
   logic [2*GX_W+1:0]        d2_sum;
   logic [D2_W-1:0]          d2_ff;
   logic [25:0]              rsq_ff;
   logic [NUM_W-1:0]         num_c, dq_ff;
   logic [25:0]              rem_ff;
   logic [26:0]              rem_sh;
   logic                     rem_ge;
   logic [4:0]               shift_n;
   logic [16:0]              tab_t, infl_c, infl_ff;
   logic [17:0]              infl_rnd;
   logic [32:0]              gain_prod;
   logic [15:0]              gain_ff;

   // update path
   logic [16:0] mag;
   logic [32:0] prod_ff;
   logic        neg_ff;
   logic [16:0] step_v;
   logic [16:0] w_ext;

   // decay
   logic [31:0] rate_dec;
   logic [28:0] radius_dec;
   logic [12:0] radius_cfg;

   logic [GX_W+3:0] bx_ext, by_ext;

   assign gw_last = GX_W'(sbst_pkg::clamp_size(grid_width_ff, GRID_MAX) - 1);
   assign gh_last = GX_W'(sbst_pkg::clamp_size(grid_height_ff, GRID_MAX) - 1);
   assign vl_last = VD_W'(sbst_pkg::clamp_size(vector_length_ff, VECTOR_MAX) - 1);

   // addresses
   assign cur_addr = ADDR_W'((int'(y_idx) * GRID_MAX + int'(x_idx)) * VECTOR_MAX
                             + int'(d_idx));
   assign req_addr = ADDR_W'((int'(req_beat.node_y) * GRID_MAX + int'(req_beat.node_x))
                             * VECTOR_MAX + int'(req_beat.element_index));
   assign req_in_range = (int'(req_beat.node_x) < GRID_MAX) &&
                         (int'(req_beat.node_y) < GRID_MAX) &&
                         (int'(req_beat.element_index) < VECTOR_MAX);

   assign w_we    = (cmd.accept && req_beat.operation == sbst_pkg::OP_WRITE && req_in_range)
                    || cmd.wr_en;
   assign w_waddr = cmd.wr_en ? cur_addr : req_addr;
   assign w_wdata = cmd.wr_en ? new_w : req_beat.value;
   assign in_we   = cmd.accept &&
                    (req_beat.operation == sbst_pkg::OP_TRAIN ||
                     req_beat.operation == sbst_pkg::OP_QUERY) &&
                    (int'(req_beat.element_index) < VECTOR_MAX);

   // weight memory
   always_ff @(posedge clock) begin
      if (w_we) weight_mem[w_waddr] <= w_wdata;
      if (cmd.rd) w_rd_ff <= weight_mem[cur_addr];
   end

   // input vector memory
   always_ff @(posedge clock) begin
      if (in_we) input_mem[VD_W'(req_beat.element_index)] <= req_beat.value;
      if (cmd.rd) in_rd_ff <= input_mem[d_idx];
   end

   // element difference, shared by search and update
   assign diff_s  = $signed({in_rd_ff[15], in_rd_ff}) - $signed({w_rd_ff[15], w_rd_ff});
   assign sq_full = diff_s * diff_s;
   assign mag     = diff_s[16] ? 17'(-diff_s) : 17'(diff_s);

   // distance accumulate and best node
   always_ff @(posedge clock) begin
      if (cmd.sq_en) sq_ff <= sq_full[32:0];
      if (cmd.acc_en) acc_ff <= ((d_idx == '0) ? '0 : acc_ff) + DIST_W'(sq_ff);
      if (cmd.cmp_en) begin
         if ((x_idx == '0 && y_idx == '0) || acc_ff < best_ff) begin
            best_ff <= acc_ff;
            bx_ff   <= x_idx;
            by_ff   <= y_idx;
         end
      end
   end

   // squared grid distance to best node
   assign dx     = $signed({1'b0, x_idx}) - $signed({1'b0, bx_ff});
   assign dy     = $signed({1'b0, y_idx}) - $signed({1'b0, by_ff});
   assign dx2    = dx * dx;
   assign dy2    = dy * dy;
   assign d2_sum = unsigned'(dx2) + unsigned'(dy2);
   assign num_c  = NUM_W'(d2_ff) * NUM_W'(sbst_pkg::LOG2E_X8) + NUM_W'(rsq_ff[25:1]);

   // restoring divider, one quotient bit per step
   assign rem_sh = {rem_ff, dq_ff[NUM_W-1]};
   assign rem_ge = rem_sh >= {1'b0, rsq_ff};

   // exponent to influence
   assign shift_n  = dq_ff[8:4];
   assign tab_t    = sbst_pkg::EXP2_FRAC[dq_ff[3:0]];
   assign infl_rnd = {1'b0, tab_t} + (18'd1 << (shift_n - 5'd1));
   always_comb begin
      if (dq_ff >= NUM_W'(sbst_pkg::EXP_SAT)) infl_c = '0;
      else if (shift_n == '0) infl_c = tab_t;
      else infl_c = 17'(infl_rnd >> shift_n);
   end
   assign gain_prod = 33'(rate_ff) * 33'(infl_ff) + sbst_pkg::HALF_Q16;

   always_ff @(posedge clock) begin
      if (cmd.d2_en) begin
         d2_ff  <= D2_W'(d2_sum);
         rsq_ff <= 26'(radius_ff) * 26'(radius_ff);
      end
      if (cmd.div_start) begin
         dq_ff  <= num_c;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff  <= {dq_ff[NUM_W-2:0], rem_ge};
         rem_ff <= rem_ge ? 26'(rem_sh - {1'b0, rsq_ff}) : rem_sh[25:0];
      end
      if (cmd.infl_en) infl_ff <= infl_c;
      if (cmd.gain_en) gain_ff <= gain_prod[31:16];
   end

   // weight step toward the input
   assign step_v = 17'((prod_ff + sbst_pkg::HALF_Q16) >> 16);
   assign w_ext  = neg_ff ? ({w_rd_ff[15], w_rd_ff} - step_v)
                          : ({w_rd_ff[15], w_rd_ff} + step_v);
   assign new_w  = w_ext[15:0];

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= 33'(mag) * 33'(gain_ff);
         neg_ff  <= diff_s[16];
      end
   end

   // decay and configuration
   assign rate_dec   = 32'(rate_ff) * 32'(sbst_pkg::DECAY_Q16);
   assign radius_dec = 29'(radius_ff) * 29'(sbst_pkg::DECAY_Q16);
   assign radius_cfg = csr_data[12:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff    <= sbst_pkg::SIZE_RESET;
         grid_height_ff   <= sbst_pkg::SIZE_RESET;
         vector_length_ff <= sbst_pkg::SIZE_RESET;
         rate_ff          <= sbst_pkg::RATE_RESET;
         radius_ff        <= sbst_pkg::RADIUS_RESET;
      end else if (csr_accept) begin
         case (csr_index)
            sbst_pkg::REG_GRID_WIDTH:    grid_width_ff    <= csr_data[4:0];
            sbst_pkg::REG_GRID_HEIGHT:   grid_height_ff   <= csr_data[4:0];
            sbst_pkg::REG_VECTOR_LENGTH: vector_length_ff <= csr_data[4:0];
            sbst_pkg::REG_INITIAL_RATE:  rate_ff          <= csr_data;
            sbst_pkg::REG_INITIAL_RADIUS: begin
               radius_ff <= (radius_cfg < sbst_pkg::RADIUS_MIN) ? sbst_pkg::RADIUS_MIN
                                                                : radius_cfg;
            end
            default: ;
         endcase
      end else if (cmd.decay_en) begin
         rate_ff   <= rate_dec[31:16];
         radius_ff <= (radius_dec[28:16] < sbst_pkg::RADIUS_MIN) ? sbst_pkg::RADIUS_MIN
                                                                 : radius_dec[28:16];
      end
   end

   // result payload
   assign bx_ext = {4'b0, bx_ff};
   assign by_ext = {4'b0, by_ff};
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_bmu_x   <= bx_ext[3:0];
         rsp_bmu_y   <= by_ext[3:0];
         rsp_updated <= cmd.train;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/som_bmu_search_and_train.sv */
// Self-organizing map: best matching node search and Kohonen training.
// req_bus carries one beat per item: a weight word write or one input
// element. Elements are stored as they arrive; the beat marked last starts
// a search over all nodes in use, and for a training element a full weight
// update and a rate/radius decay follow.
// rsp_bus returns one beat (best node, update flag) per last element.
// csr_bus writes the five registers, always ready, one per cycle.
// Search steps through each node in use: each element is read, squared and
// accumulated, then the node is compared. Training then visits each node
// again: grid distance to the best node, a bit-serial divider that forms the
// Gaussian exponent, influence and gain, then a read, multiply and write per
// element, and a final rate/radius decay.
// Inputs are not taken while a vector is processed. A finished result sits
// in the output register; the block takes new beats while it waits, and
// only the next result waits for the receiver to drain it.
// Reset clears control and loads register defaults; weights and the input
// vector hold no value until written.
`default_nettype none
module som_bmu_search_and_train #(
   parameter int GRID_MAX   = sbst_pkg::GRID_MAX_DEF,
   parameter int VECTOR_MAX = sbst_pkg::VECTOR_MAX_DEF
) (
   input wire logic clock,
   input wire logic reset,
   sbst_req_if.sink   req_bus,
   sbst_rsp_if.source rsp_bus,
   sbst_csr_if.sink   csr_bus
);
   localparam int GX_W = $clog2(GRID_MAX);
   localparam int VD_W = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1;

   sbst_pkg::cmd_type      cmd;
   sbst_pkg::req_beat_type req_beat;
   logic [GX_W-1:0] gw_last, gh_last, x_idx, y_idx;
   logic [VD_W-1:0] vl_last, d_idx;

   // payload gathering
   assign req_beat.operation     = req_bus.operation;
   assign req_beat.node_x        = req_bus.node_x;
   assign req_beat.node_y        = req_bus.node_y;
   assign req_beat.element_index = req_bus.element_index;
   assign req_beat.value         = req_bus.value;
   assign req_beat.last          = req_bus.last;
   assign csr_bus.ready          = 1'b1;

   sbst_ctrl #(.GRID_MAX(GRID_MAX), .VECTOR_MAX(VECTOR_MAX)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.operation),
      .req_last  (req_bus.last),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .gw_last   (gw_last),
      .gh_last   (gh_last),
      .vl_last   (vl_last),
      .cmd       (cmd),
      .x_idx     (x_idx),
      .y_idx     (y_idx),
      .d_idx     (d_idx)
   );

   sbst_dpath #(.GRID_MAX(GRID_MAX), .VECTOR_MAX(VECTOR_MAX)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_beat    (req_beat),
      .csr_accept  (csr_bus.valid),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data),
      .cmd         (cmd),
      .x_idx       (x_idx),
      .y_idx       (y_idx),
      .d_idx       (d_idx),
      .gw_last     (gw_last),
      .gh_last     (gh_last),
      .vl_last     (vl_last),
      .rsp_bmu_x   (rsp_bus.bmu_x),
      .rsp_bmu_y   (rsp_bus.bmu_y),
      .rsp_updated (rsp_bus.weights_updated)
   );
endmodule
`default_nettype wire
